[design/phnm_pkg.sv]
package phnm_pkg;

  // default history depth
  localparam int unsigned DepthDef = 400;

  // field widths
  localparam int unsigned TsW  = 64;
  localparam int unsigned AngW = 32;

  // input tuser codes
  localparam logic ModePush  = 1'b0;
  localparam logic ModeQuery = 1'b1;

  // one stored pose
  typedef struct packed {
    logic [TsW-1:0]  ts;
    logic [AngW-1:0] yaw;
    logic [AngW-1:0] pitch;
    logic [AngW-1:0] roll;
  } pose_t;

  // best-so-far word that walks the chain during a query
  typedef struct packed {
    logic            vld;
    logic            have;
    logic [TsW-1:0]  diff;
    logic [AngW-1:0] yaw;
    logic [AngW-1:0] pitch;
    logic [AngW-1:0] roll;
  } tok_t;

  // unsigned absolute difference of two timestamps
  function automatic logic [TsW-1:0] abs_diff(logic [TsW-1:0] a, logic [TsW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[design/phnm_cell.sv]
module phnm_cell #(
  parameter int unsigned DEPTH = phnm_pkg::DepthDef,
  parameter int unsigned IDX   = 0,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  phnm_pkg::pose_t              pose_i,
  output phnm_pkg::pose_t              pose_o,
  input  logic [phnm_pkg::TsW-1:0]     query_ts_i,
  input  logic [CntW-1:0]              count_i,
  input  phnm_pkg::tok_t               tok_i,
  output phnm_pkg::tok_t               tok_o
);

  phnm_pkg::pose_t              pose_q;
  logic [phnm_pkg::TsW-1:0]     diff_q;
  logic                         vld_q;
  phnm_pkg::tok_t               tok_d;
  phnm_pkg::tok_t               tok_q;
  logic                         occupied;
  logic                         take;

  // pose shift line, newest pose enters at cell zero
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pose_q <= pose_i;
    end
  end

  assign pose_o = pose_q;

  // distance of this pose to the frame time
  always_ff @(posedge clk_i) begin
    diff_q <= phnm_pkg::abs_diff(query_ts_i, pose_q.ts);
  end

  // this cell holds a pose when its place is below the fill count
  assign occupied = (count_i > CntW'(IDX));

  // strict compare keeps the older pose on a tie
  assign take = tok_i.vld && occupied && (!tok_i.have || (diff_q < tok_i.diff));

  always_comb begin
    tok_d = tok_i;
    if (take) begin
      tok_d.have  = 1'b1;
      tok_d.diff  = diff_q;
      tok_d.yaw   = pose_q.yaw;
      tok_d.pitch = pose_q.pitch;
      tok_d.roll  = pose_q.roll;
    end
  end

  // token valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld;
    end
  end

  // token payload
  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = vld_q;
  end

endmodule

[design/pose_history_nearest_match.sv]
// pose history with nearest-timestamp match
//
// slave stream: tuser carries mode (0 push pose, 1 query), tdata carries the
// timestamp and the three angle words. a push word shifts the pose into a
// row of DEPTH cells, dropping the oldest once full; it gives no output word.
// a query word loads the frame time and launches a best-so-far token at the
// oldest cell; it walks one cell per clock toward the newest, and its result
// is then loaded into the output register. s_axis_tready stays low from the
// query until its result sits in the output register, so no new word is taken
// during a scan, and pushes run at one per cycle otherwise.
// master stream: tuser is found, tdata holds yaw, pitch, roll (zero when the
// history is empty). the output register holds its word while m_axis_tready
// is low; a finished scan waits in a holding register meanwhile.
// reset empties the history and drops any query in flight.
module pose_history_nearest_match #(
  parameter int unsigned DEPTH = phnm_pkg::DepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // timestamp_ms[63:0], yaw_in[95:64], pitch_in[127:96], roll_in[159:128]
  input  logic [159:0] s_axis_tdata,
  // mode[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // yaw_out[31:0], pitch_out[63:32], roll_out[95:64]
  output logic [95:0]  m_axis_tdata,
  // found[0]
  output logic         m_axis_tuser
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                       in_fire;
  logic                       push;
  logic                       query;
  phnm_pkg::pose_t            in_pose;
  logic [CntW-1:0]            count_q, count_d;
  logic [phnm_pkg::TsW-1:0]   query_ts_q;
  logic                       start_q, inj_q;
  logic                       busy_q, busy_d;
  phnm_pkg::tok_t             inj_tok;
  phnm_pkg::pose_t            pose_w [DEPTH];
  phnm_pkg::tok_t             tok_w  [DEPTH];
  logic                       pend_vld_q, pend_vld_d;
  phnm_pkg::tok_t             pend_q;
  logic                       out_vld_q, out_vld_d;
  logic                       out_load;
  logic                       out_found_q;
  logic [95:0]                out_data_q;

  // input handshake and field split
  assign s_axis_tready = !busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign push          = in_fire && (s_axis_tuser == phnm_pkg::ModePush);
  assign query         = in_fire && (s_axis_tuser == phnm_pkg::ModeQuery);

  assign in_pose.ts    = s_axis_tdata[63:0];
  assign in_pose.yaw   = s_axis_tdata[95:64];
  assign in_pose.pitch = s_axis_tdata[127:96];
  assign in_pose.roll  = s_axis_tdata[159:128];

  // fill count saturates at DEPTH
  always_comb begin
    count_d = count_q;
    if (push && (count_q < CntW'(DEPTH))) begin
      count_d = count_q + CntW'(1);
    end
  end

  // frame time for the scan
  always_ff @(posedge clk_i) begin
    if (query) begin
      query_ts_q <= s_axis_tdata[63:0];
    end
  end

  // empty token enters the oldest cell once the cell distances are settled
  always_comb begin
    inj_tok       = '0;
    inj_tok.vld   = inj_q;
  end

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    phnm_pkg::pose_t pose_in;
    phnm_pkg::tok_t  tok_in;

    if (i == 0) begin : g_head
      assign pose_in = in_pose;
    end else begin : g_body
      assign pose_in = pose_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign tok_in = inj_tok;
    end else begin : g_mid
      assign tok_in = tok_w[i+1];
    end

    phnm_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (push),
      .pose_i     (pose_in),
      .pose_o     (pose_w[i]),
      .query_ts_i (query_ts_q),
      .count_i    (count_q),
      .tok_i      (tok_in),
      .tok_o      (tok_w[i])
    );
  end

  // finished token waits here until the output register is free
  assign out_load = pend_vld_q && (!out_vld_q || m_axis_tready);

  always_comb begin
    pend_vld_d = pend_vld_q;
    if (tok_w[0].vld) begin
      pend_vld_d = 1'b1;
    end else if (out_load) begin
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_w[0].vld) begin
      pend_q <= tok_w[0];
    end
  end

  // busy from query until its result is in the output register
  always_comb begin
    busy_d = busy_q;
    if (query) begin
      busy_d = 1'b1;
    end else if (out_load) begin
      busy_d = 1'b0;
    end
  end

  // output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= pend_q.have;
      out_data_q  <= {pend_q.roll, pend_q.pitch, pend_q.yaw};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      start_q    <= 1'b0;
      inj_q      <= 1'b0;
      busy_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      count_q    <= count_d;
      start_q    <= query;
      inj_q      <= start_q;
      busy_q     <= busy_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_found_q;

endmodule

[design/phnm_checker.sv]
module phnm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [95:0]  m_axis_tdata,
  input logic         m_axis_tuser
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // a query closes the input until its result is out
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == phnm_pkg::ModeQuery)
      |=> !s_axis_tready)
    else $error("input open during a scan");

  // no match means zero angles
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == 96'd0))
    else $error("angles not zero without a match");

  // a result only appears at the end of a scan
  a_result_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a scan in progress");

endmodule

bind pose_history_nearest_match phnm_checker u_phnm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
